// File: src/ths_pkg.sv
package ths_pkg;

	localparam int MAP_SIDE_DEF    = 256;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int POS_W   = 32;
	localparam int IDX_W   = 16;
	localparam int VAL_W   = 16;
	localparam int MW_W    = 9;
	localparam int DW      = 33;
	localparam int CELL_W  = 9;
	localparam int ADDR_W  = 21;

	localparam int DIV1_STEPS = DW;
	localparam int DIV2_STEPS = CELL_W;
	localparam int LOC_LAT    = DIV1_STEPS + DIV2_STEPS + 3;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [1:0] {
		REG_TILE  = 2'd0,
		REG_GAIN  = 2'd1,
		REG_WIDTH = 2'd2,
		REG_ROWS  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [31:0]     tile;
		logic [31:0]     gain;
		logic [MW_W-1:0] width;
		logic [MW_W-1:0] rows;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic query;
	} tag_t;

endpackage

// File: src/terrain_height_sampler.sv
// Terrain height sampler.
// Input stream (s_*): tuser[0] selects load (0) or query (1). A load writes
// sample_value at sample_index and gives no result; a query gives one result.
// Output stream (m_*): tdata = height, tuser[0] = out_of_range.
// Configuration: APB, registers tile_size, vertical_gain, map_width, map_rows
// at byte addresses 0, 4, 8, 12; write only while no request is in flight.
// Path: the two bit-per-stage dividers for the tile remainder and cell split,
// the corner read and the bit-per-stage plane divider.
// Throughput: one request per cycle unless stalled; loads and queries share
// one pipeline, so a query sees every earlier load without forwarding.
// Stall: the pipeline freezes only when a finished result sits in the output
// register, is not taken, and another result reaches the last stage.
// Reset clears all valid state and sets the configuration registers to their
// defaults; sample memory contents stay undefined until loaded.
module terrain_height_sampler import ths_pkg::*; #(
	parameter int MAP_SIDE    = MAP_SIDE_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,  // pos_x, pos_z, sample_index, sample_value
	input  logic [0:0]  s_tuser,  // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // height
	output logic [0:0]  m_tuser,  // out_of_range
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int DEPTH   = MAP_SIDE * MAP_SIDE;
	localparam int AW      = $clog2(DEPTH);
	localparam int SB      = SAMPLE_BITS;
	localparam int QB      = SB + 16;
	localparam int INT_LAT = QB + 3;

	cfg_t             cfg;
	logic             en;
	logic [31:0]      tile_eff;
	logic [DW-1:0]    d;
	tag_t             tag_in;
	logic [SB+15:0]   val_ext;

	tag_t             tag_loc [0:LOC_LAT-1];
	logic [IDX_W-1:0] idx_loc [0:LOC_LAT-1];
	logic [SB-1:0]    val_loc [0:LOC_LAT-1];

	logic [CELL_W-1:0] x0, z0;
	logic [DW-1:0]     ru, rv;

	logic [17:0]       i00_mul_c;
	logic [ADDR_W-1:0] i00_c, top_c, size_c, rw_c;

	tag_t              tag_s1;
	logic [ADDR_W-1:0] i00_s1;
	logic              oor_s1;
	logic [DW-1:0]     ru_s1, rv_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [SB-1:0]     val_s1;

	logic              ld_ok;
	logic [3:0][AW-1:0] raddr;
	logic [3:0][SB-1:0] rdata;
	logic [ADDR_W-1:0] a1_c, a2_c, a3_c;

	tag_t              tag_s2;
	logic              oor_s2, tri_s2;
	logic [DW-1:0]     wa_s2, wb_s2, wc_s2;

	tag_t              tag_int [0:INT_LAT-1];
	logic              oor_int [0:INT_LAT-1];
	logic [QB+31:0]    prod;
	logic              last_vq;

	ths_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign tile_eff = (cfg.tile == 32'd0) ? 32'd1 : cfg.tile;
	assign d        = {tile_eff, 1'b0};

	assign last_vq  = tag_int[INT_LAT-1].valid && tag_int[INT_LAT-1].query;
	assign en       = !(m_tvalid && !m_tready && last_vq);
	assign s_tready = en;

	assign tag_in.valid = s_tvalid && en;
	assign tag_in.query = (s_tuser[0] == OP_QUERY);
	assign val_ext      = {{SB{1'b0}}, s_tdata[95:80]};

	ths_loc u_loc_x (
		.clk      (clk),
		.en       (en),
		.pos      (s_tdata[31:0]),
		.tile     (cfg.tile),
		.d        (d),
		.width    (cfg.width),
		.cell_idx (x0),
		.rem      (ru)
	);

	ths_loc u_loc_z (
		.clk      (clk),
		.en       (en),
		.pos      (s_tdata[63:32]),
		.tile     (cfg.tile),
		.d        (d),
		.width    (cfg.width),
		.cell_idx (z0),
		.rem      (rv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LOC_LAT; i++) tag_loc[i] <= '0;
			tag_s1 <= '0;
			tag_s2 <= '0;
			for (int i = 0; i < INT_LAT; i++) tag_int[i] <= '0;
		end else if (en) begin
			tag_loc[0] <= tag_in;
			for (int i = 1; i < LOC_LAT; i++) tag_loc[i] <= tag_loc[i-1];
			tag_s1     <= tag_loc[LOC_LAT-1];
			tag_s2     <= tag_s1;
			tag_int[0] <= tag_s2;
			for (int i = 1; i < INT_LAT; i++) tag_int[i] <= tag_int[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_loc[0] <= s_tdata[79:64];
			val_loc[0] <= val_ext[SB-1:0];
			for (int i = 1; i < LOC_LAT; i++) begin
				idx_loc[i] <= idx_loc[i-1];
				val_loc[i] <= val_loc[i-1];
			end
		end
	end

	assign i00_mul_c = cfg.width * z0;
	assign i00_c     = ADDR_W'(i00_mul_c) + ADDR_W'(x0);
	assign top_c     = i00_c + ADDR_W'(cfg.width) + ADDR_W'(1);
	assign rw_c      = ADDR_W'(cfg.rows) * ADDR_W'(cfg.width);
	assign size_c    = (rw_c < ADDR_W'(DEPTH)) ? rw_c : ADDR_W'(DEPTH);

	always_ff @(posedge clk) begin
		if (en) begin
			i00_s1 <= i00_c;
			oor_s1 <= top_c >= size_c;
			ru_s1  <= ru;
			rv_s1  <= rv;
			idx_s1 <= idx_loc[LOC_LAT-1];
			val_s1 <= val_loc[LOC_LAT-1];
		end
	end

	assign ld_ok = tag_s1.valid && !tag_s1.query && (ADDR_W'(idx_s1) < ADDR_W'(DEPTH));
	assign a1_c  = i00_s1 + ADDR_W'(1);
	assign a2_c  = i00_s1 + ADDR_W'(cfg.width);
	assign a3_c  = a2_c + ADDR_W'(1);
	assign raddr[0] = i00_s1[AW-1:0];
	assign raddr[1] = a1_c[AW-1:0];
	assign raddr[2] = a2_c[AW-1:0];
	assign raddr[3] = a3_c[AW-1:0];

	ths_store #(.DEPTH(DEPTH), .SB(SB), .AW(AW)) u_store (
		.clk   (clk),
		.en    (en),
		.we    (ld_ok),
		.waddr (AW'(idx_s1)),
		.wdata (val_s1),
		.raddr (raddr),
		.rdata (rdata)
	);

	// triangle weights: h0*(d-max) + hm*|ru-rv| + h3*min
	always_ff @(posedge clk) begin
		if (en) begin
			oor_s2 <= oor_s1;
			tri_s2 <= ru_s1 > rv_s1;
			if (ru_s1 > rv_s1) begin
				wa_s2 <= d - ru_s1;
				wb_s2 <= ru_s1 - rv_s1;
				wc_s2 <= rv_s1;
			end else begin
				wa_s2 <= d - rv_s1;
				wb_s2 <= rv_s1 - ru_s1;
				wc_s2 <= ru_s1;
			end
		end
	end

	ths_interp #(.SB(SB), .QB(QB)) u_interp (
		.clk  (clk),
		.en   (en),
		.h0   (rdata[0]),
		.hm   (tri_s2 ? rdata[1] : rdata[2]),
		.h3   (rdata[3]),
		.wa   (wa_s2),
		.wb   (wb_s2),
		.wc   (wc_s2),
		.d    (d),
		.gain (cfg.gain),
		.prod (prod)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			oor_int[0] <= oor_s2;
			for (int i = 1; i < INT_LAT; i++) oor_int[i] <= oor_int[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en && last_vq) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && last_vq) begin
			m_tdata    <= oor_int[INT_LAT-1] ? 32'd0 : prod[QB+31:QB];
			m_tuser[0] <= oor_int[INT_LAT-1];
		end
	end

endmodule

// File: src/ths_cfg.sv
module ths_cfg import ths_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	reg_idx_t idx;
	cfg_t     cfg_q;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tile  <= 32'd65536;
			cfg_q.gain  <= 32'd65536;
			cfg_q.width <= 9'd256;
			cfg_q.rows  <= 9'd256;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_TILE:  cfg_q.tile  <= pwdata;
				REG_GAIN:  cfg_q.gain  <= pwdata;
				REG_WIDTH: cfg_q.width <= pwdata[MW_W-1:0];
				REG_ROWS:  cfg_q.rows  <= pwdata[MW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_TILE:  prdata = cfg_q.tile;
			REG_GAIN:  prdata = cfg_q.gain;
			REG_WIDTH: prdata = {23'd0, cfg_q.width};
			REG_ROWS:  prdata = {23'd0, cfg_q.rows};
			default:   prdata = 32'd0;
		endcase
	end

endmodule

// File: src/ths_loc.sv
module ths_loc import ths_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [POS_W-1:0] pos,
	input  logic [31:0]             tile,
	input  logic [DW-1:0]           d,
	input  logic [MW_W-1:0]         width,
	output logic [CELL_W-1:0]       cell_idx,
	output logic [DW-1:0]           rem
);

	logic signed [34:0] n_c;
	logic [34:0]        nabs_c;
	logic [DW-1:0]      rem_s [0:DIV1_STEPS];
	logic [DW-1:0]      dvd_s [0:DIV1_STEPS];
	logic               neg_s [0:DIV1_STEPS];
	logic [DW-1:0]      fix_s;
	logic [DW+MW_W-1:0] prod_c;
	logic [DW-1:0]      rr_s  [0:DIV2_STEPS];
	logic [CELL_W-1:0]  lo_s  [0:DIV2_STEPS];
	logic [CELL_W-1:0]  qq_s  [0:DIV2_STEPS];

	assign n_c    = $signed({{2{pos[POS_W-1]}}, pos, 1'b0}) + $signed({3'd0, tile});
	assign nabs_c = n_c[34] ? 35'(-n_c) : 35'(n_c);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= '0;
			dvd_s[0] <= nabs_c[DW-1:0];
			neg_s[0] <= n_c[34];
		end
	end

	// |n| mod d, one bit per stage
	for (genvar k = 1; k <= DIV1_STEPS; k++) begin : g_div1
		logic [DW:0] t;
		logic [DW:0] diff;
		assign t    = {rem_s[k-1], dvd_s[k-1][DW-1]};
		assign diff = t - {1'b0, d};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= (t >= {1'b0, d}) ? diff[DW-1:0] : t[DW-1:0];
				dvd_s[k] <= {dvd_s[k-1][DW-2:0], 1'b0};
				neg_s[k] <= neg_s[k-1];
			end
		end
	end

	// floor correction for negative coordinates
	always_ff @(posedge clk) begin
		if (en) begin
			fix_s <= (neg_s[DIV1_STEPS] && rem_s[DIV1_STEPS] != '0) ?
				d - rem_s[DIV1_STEPS] : rem_s[DIV1_STEPS];
		end
	end

	assign prod_c = fix_s * width;

	always_ff @(posedge clk) begin
		if (en) begin
			rr_s[0] <= prod_c[DW+MW_W-1:CELL_W];
			lo_s[0] <= prod_c[CELL_W-1:0];
			qq_s[0] <= '0;
		end
	end

	for (genvar k = 1; k <= DIV2_STEPS; k++) begin : g_div2
		logic [DW:0] t;
		logic [DW:0] diff;
		logic        ge;
		assign t    = {rr_s[k-1], lo_s[k-1][CELL_W-1]};
		assign diff = t - {1'b0, d};
		assign ge   = t >= {1'b0, d};
		always_ff @(posedge clk) begin
			if (en) begin
				rr_s[k] <= ge ? diff[DW-1:0] : t[DW-1:0];
				lo_s[k] <= {lo_s[k-1][CELL_W-2:0], 1'b0};
				qq_s[k] <= {qq_s[k-1][CELL_W-2:0], ge};
			end
		end
	end

	assign cell_idx = qq_s[DIV2_STEPS];
	assign rem      = rr_s[DIV2_STEPS];

endmodule

// File: src/ths_store.sv
module ths_store #(
	parameter int DEPTH = 65536,
	parameter int SB    = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [SB-1:0]        wdata,
	input  logic [3:0][AW-1:0]   raddr,
	output logic [3:0][SB-1:0]   rdata
);

	// two copies so four corners read in the same cycle
	logic [SB-1:0] mem_a [0:DEPTH-1];
	logic [SB-1:0] mem_b [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (en && we) begin
			mem_a[waddr] <= wdata;
			mem_b[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rdata[0] <= mem_a[raddr[0]];
			rdata[1] <= mem_a[raddr[1]];
			rdata[2] <= mem_b[raddr[2]];
			rdata[3] <= mem_b[raddr[3]];
		end
	end

endmodule

// File: src/ths_interp.sv
module ths_interp #(
	parameter int SB = 16,
	parameter int QB = SB + 16
) (
	input  logic           clk,
	input  logic           en,
	input  logic [SB-1:0]  h0,
	input  logic [SB-1:0]  hm,
	input  logic [SB-1:0]  h3,
	input  logic [32:0]    wa,
	input  logic [32:0]    wb,
	input  logic [32:0]    wc,
	input  logic [32:0]    d,
	input  logic [31:0]    gain,
	output logic [QB+31:0] prod
);

	localparam int NW = SB + 33;

	logic [NW-1:0]   pa_s, pb_s, pc_s;
	logic [NW-1:0]   sum_c;
	logic [32:0]     rem_s [0:QB];
	logic [QB-1:0]   lo_s  [0:QB];
	logic [QB-1:0]   qq_s  [0:QB];
	logic [QB+31:0]  prod_s;

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s <= h0 * wa;
			pb_s <= hm * wb;
			pc_s <= h3 * wc;
		end
	end

	assign sum_c = pa_s + pb_s + pc_s;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= sum_c[NW-1:SB];
			lo_s[0]  <= {sum_c[SB-1:0], 16'd0};
			qq_s[0]  <= '0;
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_div
		logic [33:0] t;
		logic [33:0] diff;
		logic        ge;
		assign t    = {rem_s[k-1], lo_s[k-1][QB-1]};
		assign diff = t - {1'b0, d};
		assign ge   = t >= {1'b0, d};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[32:0] : t[32:0];
				lo_s[k]  <= {lo_s[k-1][QB-2:0], 1'b0};
				qq_s[k]  <= {qq_s[k-1][QB-2:0], ge};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s <= qq_s[QB] * gain;
		end
	end

	assign prod = prod_s;

endmodule
